[rtl/core/pqt_pkg.sv]
// ----------------------------------------------------------------------------
// pqt_pkg
// Shared constants and types for the projective quad transform core.
// ----------------------------------------------------------------------------
package pqt_pkg;

    localparam int COORD_WIDTH = 24;
    localparam int COEFF_WIDTH = 32;
    localparam int COORD_FRAC  = 8;
    localparam int AREA_WIDTH  = 52;

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_MAC   = 6'b000010,
        ST_DIV   = 6'b000100,
        ST_GEOM  = 6'b001000,
        ST_AREA  = 6'b010000,
        ST_OUT   = 6'b100000
    } state_t;

endpackage

[rtl/core/projective_quad_transform_core.sv]
// ----------------------------------------------------------------------------
// projective_quad_transform_core
// Maps quad vertices through a 3x3 homography and checks quad convexity/area.
// ----------------------------------------------------------------------------
// Input channel s_axis_*: one transaction carries nine homography
// coefficients (Q16.16) and one vertex (Q16.8). Output channel m_axis_*:
// one transaction per input with the projected vertex, at_infinity in
// tuser and, on every fourth vertex, quad_complete in tlast and the
// convex/area result of the quad.
// One item is processed at a time. X, Y and W are formed by a bit-serial
// multiply-accumulate; the shared restoring divider then gives both
// quotients one bit per cycle (it is skipped, with a zero vertex, when W
// is zero); on a fourth vertex the serial cross products and then the
// area follow. The divider loop takes the largest share of the time that
// an item needs.
// Reset clears the vertex counter and the infinity flag; stored vertices
// are undefined until written. When the receiver stalls the result stays in
// the output register and s_axis_tready stays low; it returns high the cycle
// after the result has been taken.
// ----------------------------------------------------------------------------
module projective_quad_transform_core #(
    parameter int COORD_WIDTH = pqt_pkg::COORD_WIDTH,
    parameter int COEFF_WIDTH = pqt_pkg::COEFF_WIDTH
) (
    input  logic clk,
    input  logic rst_n,
    input  logic s_axis_tvalid,
    output logic s_axis_tready,
    // h_xx,h_xy,h_xt,h_yx,h_yy,h_yt,h_wx,h_wy,h_wt,x_in,y_in (low first)
    input  logic [((9*COEFF_WIDTH+2*COORD_WIDTH+7)/8)*8-1:0] s_axis_tdata,
    output logic m_axis_tvalid,
    input  logic m_axis_tready,
    // x_out,y_out,convex_cw,quad_area (low first)
    output logic [((2*COORD_WIDTH+1+2*COORD_WIDTH+4+7)/8)*8-1:0] m_axis_tdata,
    // at_infinity
    output logic m_axis_tuser,
    // quad_complete
    output logic m_axis_tlast
);
    localparam int CW   = COORD_WIDTH;
    localparam int KW   = COEFF_WIDTH;
    localparam int PW   = KW + CW + 3;        // X, Y, W accumulator width
    localparam int AW   = 2*CW + 4;            // area width
    localparam int ODW  = ((2*CW+1+AW+7)/8)*8;
    localparam int QW   = PW + pqt_pkg::COORD_FRAC;   // quotient bits
    localparam int DW   = 2*CW + 4;            // cross product width
    localparam int NW   = CW + 1;              // normal width
    localparam int CNTW = $clog2(QW + 2);
    localparam logic [CW-1:0] LIMP = {1'b0, {(CW-1){1'b1}}};

    pqt_pkg::state_t state_reg, state_next;

    logic signed [KW-1:0] h_reg [9];
    logic signed [CW-1:0] yin_reg;
    logic [CNTW-1:0]      cnt_reg;
    logic [1:0]           phase_reg;          // MAC: term; DIV: 0=X,1=Y; GEOM: index
    logic signed [PW-1:0] acc_reg [3];
    logic [CW:0]          mshift_reg;         // serial multiplier operand
    logic [PW-1:0]        rem_reg;
    logic [QW-1:0]        quo_reg;
    logic [PW-1:0]        den_reg;
    logic [CW-1:0]        px_reg, py_reg;
    logic                 inf_reg;
    logic [1:0]           vcount_reg;
    logic                 infseen_reg;
    logic [CW-1:0]        sx_reg [3];
    logic [CW-1:0]        sy_reg [3];
    logic signed [DW-1:0] csum_reg;           // c0 + c2
    logic                 convex_reg;
    logic signed [AW-1:0] area_reg;
    logic                 complete_reg;
    logic                 ovalid_reg;

    // serial multiply: one coordinate bit per cycle, three products in parallel
    logic signed [KW-1:0] ma [3];
    logic                 mbit;
    logic                 msign;
    always_comb
    begin
        case (phase_reg)
            2'd0:    begin ma[0] = h_reg[0]; ma[1] = h_reg[3]; ma[2] = h_reg[6]; end
            2'd1:    begin ma[0] = h_reg[1]; ma[1] = h_reg[4]; ma[2] = h_reg[7]; end
            default: begin ma[0] = h_reg[2]; ma[1] = h_reg[5]; ma[2] = h_reg[8]; end
        endcase
    end
    assign mbit  = mshift_reg[0];
    assign msign = (cnt_reg == CNTW'(CW));    // top bit of operand carries negative weight

    // divider step
    logic             num_neg, den_neg, qneg;
    logic [PW-1:0]    an, ad;
    logic [PW:0]      trial;
    logic [PW-1:0]    rem_sh;
    assign num_neg = (phase_reg == 2'd0) ? acc_reg[0][PW-1] : acc_reg[1][PW-1];
    assign den_neg = acc_reg[2][PW-1];
    assign qneg    = num_neg ^ den_neg;
    assign an      = num_neg ? PW'(0) - ((phase_reg == 2'd0) ? acc_reg[0] : acc_reg[1])
                             : ((phase_reg == 2'd0) ? acc_reg[0] : acc_reg[1]);
    assign ad      = den_neg ? PW'(0) - acc_reg[2] : acc_reg[2];
    assign rem_sh  = {rem_reg[PW-2:0], quo_reg[QW-1]};
    assign trial   = {1'b0, rem_sh} - {1'b0, den_reg};

    // saturation of finished quotient
    logic [CW-1:0] qmag;
    logic [CW-1:0] qsat;
    logic          qbig;
    assign qbig = (quo_reg[QW-1:CW-1] != '0) ||
                  (!qneg && (quo_reg[CW-1:0] > LIMP));
    assign qmag = qbig ? (qneg ? {1'b1, {(CW-1){1'b0}}} : LIMP) : quo_reg[CW-1:0];
    assign qsat = qneg ? (CW'(0) - qmag) : qmag;

    // geometry: one cross product per cycle
    logic signed [CW-1:0] vx [4];
    logic signed [CW-1:0] vy [4];
    logic signed [NW-1:0] nxa, nya, nxb, nyb;
    logic [1:0]           ia, ib, ic;
    logic signed [DW-1:0] cprod;
    always_comb
    begin
        vx[0] = sx_reg[0]; vx[1] = sx_reg[1]; vx[2] = sx_reg[2]; vx[3] = px_reg;
        vy[0] = sy_reg[0]; vy[1] = sy_reg[1]; vy[2] = sy_reg[2]; vy[3] = py_reg;
        ia = phase_reg;
        ib = phase_reg + 2'd1;
        ic = phase_reg + 2'd2;
        nxa = NW'(vy[ib]) - NW'(vy[ia]);
        nya = NW'(vx[ia]) - NW'(vx[ib]);
        nxb = NW'(vy[ic]) - NW'(vy[ib]);
        nyb = NW'(vx[ib]) - NW'(vx[ic]);
        cprod = DW'(nxa) * DW'(nyb) - DW'(nxb) * DW'(nya);
    end

    logic signed [AW-1:0] neg_sum;
    logic signed [AW-1:0] half;
    assign neg_sum = -AW'(csum_reg);
    assign half    = (neg_sum + $signed({{(AW-1){1'b0}}, neg_sum[AW-1]})) >>> 1;

    assign s_axis_tready = state_reg[0] && !ovalid_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            pqt_pkg::ST_IDLE: if (s_axis_tvalid && s_axis_tready) state_next = pqt_pkg::ST_MAC;
            pqt_pkg::ST_MAC:
                if (phase_reg == 2'd2 && cnt_reg == CNTW'(CW)) state_next = pqt_pkg::ST_DIV;
            pqt_pkg::ST_DIV:
                if (acc_reg[2] == '0 || (phase_reg == 2'd1 && cnt_reg == CNTW'(QW + 1)))
                    state_next = (vcount_reg == 2'd3) ? pqt_pkg::ST_GEOM : pqt_pkg::ST_OUT;
            pqt_pkg::ST_GEOM:
                if (phase_reg == 2'd3 || infseen_reg || acc_reg[2] == '0)
                    state_next = pqt_pkg::ST_AREA;
            pqt_pkg::ST_AREA: state_next = pqt_pkg::ST_OUT;
            pqt_pkg::ST_OUT:  state_next = pqt_pkg::ST_IDLE;
            default:          state_next = pqt_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= pqt_pkg::ST_IDLE;
            vcount_reg   <= '0;
            infseen_reg  <= 1'b0;
            ovalid_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (m_axis_tvalid && m_axis_tready)
                ovalid_reg <= 1'b0;
            if (state_reg == pqt_pkg::ST_OUT)
            begin
                ovalid_reg <= 1'b1;
                if (vcount_reg == 2'd3)
                begin
                    vcount_reg  <= '0;
                    infseen_reg <= 1'b0;
                end
                else
                begin
                    vcount_reg  <= vcount_reg + 2'd1;
                    infseen_reg <= infseen_reg | inf_reg;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            pqt_pkg::ST_IDLE:
                if (s_axis_tvalid && s_axis_tready)
                begin
                    for (int i = 0; i < 9; i++)
                        h_reg[i] <= s_axis_tdata[i*KW +: KW];
                    yin_reg    <= s_axis_tdata[9*KW+CW +: CW];
                    mshift_reg <= {s_axis_tdata[9*KW+CW-1], s_axis_tdata[9*KW +: CW]};
                    for (int i = 0; i < 3; i++)
                        acc_reg[i] <= '0;
                    cnt_reg   <= '0;
                    phase_reg <= 2'd0;
                end
            pqt_pkg::ST_MAC:
            begin
                for (int i = 0; i < 3; i++)
                    if (mbit)
                    begin
                        if (msign)
                            acc_reg[i] <= acc_reg[i] - (PW'(ma[i]) <<< cnt_reg);
                        else
                            acc_reg[i] <= acc_reg[i] + (PW'(ma[i]) <<< cnt_reg);
                    end
                mshift_reg <= mshift_reg >> 1;
                if (cnt_reg == CNTW'(CW))
                begin
                    cnt_reg   <= '0;
                    phase_reg <= phase_reg + 2'd1;
                    if (phase_reg == 2'd0)
                        mshift_reg <= {yin_reg[CW-1], yin_reg};
                    else
                        mshift_reg <= (CW+1)'(1 << pqt_pkg::COORD_FRAC);
                    if (phase_reg == 2'd2)
                        phase_reg <= 2'd0;
                end
                else
                    cnt_reg <= cnt_reg + CNTW'(1);
            end
            pqt_pkg::ST_DIV:
            begin
                inf_reg <= (acc_reg[2] == '0);
                if (acc_reg[2] == '0)
                begin
                    px_reg <= '0;
                    py_reg <= '0;
                    phase_reg <= 2'd0;
                end
                else if (cnt_reg == '0)
                begin
                    den_reg <= ad;
                    rem_reg <= '0;
                    quo_reg <= {an, {pqt_pkg::COORD_FRAC{1'b0}}};
                    cnt_reg <= cnt_reg + CNTW'(1);
                end
                else if (cnt_reg == CNTW'(QW + 1))
                begin
                    if (phase_reg == 2'd0)
                        px_reg <= qsat;
                    else
                        py_reg <= qsat;
                    cnt_reg   <= '0;
                    phase_reg <= (phase_reg == 2'd0) ? 2'd1 : 2'd0;
                end
                else
                begin
                    if (!trial[PW])
                    begin
                        rem_reg <= trial[PW-1:0];
                        quo_reg <= {quo_reg[QW-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg <= rem_sh;
                        quo_reg <= {quo_reg[QW-2:0], 1'b0};
                    end
                    cnt_reg <= cnt_reg + CNTW'(1);
                end
                csum_reg   <= '0;
                convex_reg <= 1'b1;
            end
            pqt_pkg::ST_GEOM:
            begin
                if (cprod > 0)
                    convex_reg <= 1'b0;
                if (phase_reg == 2'd0 || phase_reg == 2'd2)
                    csum_reg <= csum_reg + cprod;
                phase_reg  <= phase_reg + 2'd1;
            end
            pqt_pkg::ST_AREA:
            begin
                complete_reg <= (vcount_reg == 2'd3);
                if (infseen_reg || inf_reg)
                begin
                    convex_reg <= 1'b0;
                    area_reg   <= '0;
                end
                else
                    area_reg <= half;
            end
            pqt_pkg::ST_OUT:
            begin
                if (vcount_reg != 2'd3)
                begin
                    sx_reg[vcount_reg] <= px_reg;
                    sy_reg[vcount_reg] <= py_reg;
                    complete_reg <= 1'b0;
                    convex_reg   <= 1'b0;
                    area_reg     <= '0;
                end
            end
            default: ;
        endcase
    end

    assign m_axis_tvalid = ovalid_reg;
    assign m_axis_tuser  = inf_reg;
    assign m_axis_tlast  = complete_reg;
    assign m_axis_tdata  = ODW'({area_reg, convex_reg, py_reg, px_reg});

    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tready |-> state_reg == pqt_pkg::ST_IDLE)
        else $error("ready outside idle");
    a_one_hot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(state_reg))
        else $error("state not one-hot");
    a_last_count: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tlast) |-> vcount_reg == 2'd0)
        else $error("quad end without count wrap");
    a_inf_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser) |-> (px_reg == '0 && py_reg == '0))
        else $error("point at infinity not zero");

endmodule
